// ===== design/rrts_pkg.sv =====
// Package for the round-robin task scheduler: defaults, result status codes,
// register map and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rrts_pkg;

    localparam int DEF_MAX_TASKS  = 16;
    localparam int DEF_BURST_BITS = 16;

    localparam int          QUANTUM_BITS  = 16;
    localparam logic [15:0] QUANTUM_RESET = 16'd10;

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    // Register index, taken from paddr[2] (registers sit at byte address 4*i).
    localparam logic REG_QUANTUM = 1'b0;

    localparam logic MODE_ADD = 1'b0;
    localparam logic MODE_RUN = 1'b1;

    typedef enum logic [1:0] {
        ST_ADDED    = 2'd0,
        ST_REJECTED = 2'd1,
        ST_RAN      = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef struct packed {
        logic accept;  // latch the input transaction
        logic q_rd;    // read the run queue at the head
        logic b_rd;    // read the burst table at the head task
        logic commit;  // update state and load the output register
    } cmd_t;

    typedef struct packed {
        logic q_empty;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

// ===== design/rrts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rrts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== design/rrts_ctrl.sv =====
// Controller of the round-robin task scheduler: sequences accept, table reads
// and commit. Depends on rrts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rrts_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    input  wire logic           s_mode,
    output logic                s_ready,
    input  wire rrts_pkg::stat_t stat,
    output rrts_pkg::cmd_t      cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_COMMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                // The head entry is read every idle cycle so that its task
                // number is ready the cycle after a run transaction.
                cmd.q_rd = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (s_mode == rrts_pkg::MODE_RUN && !stat.q_empty) begin
                        state_next = S_READ;
                    end else begin
                        state_next = S_COMMIT;
                    end
                end
            end
            S_READ: begin
                cmd.b_rd   = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/rrts_datapath.sv =====
// Datapath of the round-robin task scheduler: queue pointers, time counter,
// run queue and burst table memories, slice arithmetic and output register.
// Depends on rrts_pkg and rrts_ram.
`timescale 1ns / 1ps
`default_nettype none
module rrts_datapath #(
    parameter int MAX_TASKS  = rrts_pkg::DEF_MAX_TASKS,
    parameter int BURST_BITS = rrts_pkg::DEF_BURST_BITS
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire rrts_pkg::cmd_t  cmd,
    output rrts_pkg::stat_t      stat,
    input  wire logic [15:0]     quantum,
    input  wire logic            s_mode,
    input  wire logic [15:0]     s_burst,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [1:0]           m_status,
    output logic [3:0]           m_task_id,
    output logic [15:0]          m_run_length,
    output logic                 m_finished,
    output logic [31:0]          m_wait_time,
    output logic [31:0]          m_turnaround_time,
    output logic [31:0]          m_elapsed_time
);

    localparam int IDW = $clog2(MAX_TASKS);
    localparam int CW  = $clog2(MAX_TASKS + 1);
    localparam int BB  = BURST_BITS;
    localparam int CMPW = (BURST_BITS > 16) ? BURST_BITS : 16;

    logic [IDW-1:0] head_reg, head_next;
    logic [IDW-1:0] tail_reg, tail_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  next_id_reg, next_id_next;
    logic [31:0]    time_reg, time_next;
    logic           mode_reg;
    logic [BB-1:0]  burst_in_reg;

    logic             valid_reg;
    rrts_pkg::status_t status_reg, status_next;
    logic [3:0]       task_id_reg, task_id_next;
    logic [15:0]      run_length_reg, run_length_next;
    logic             finished_reg, finished_next;
    logic [31:0]      wait_reg, wait_next;
    logic [31:0]      tat_reg, tat_next;

    logic           q_wr_en;
    logic [IDW-1:0] q_wr_data;
    logic [IDW-1:0] q_rd_data;
    logic           b_wr_en;
    logic [IDW-1:0] b_wr_addr;
    logic [2*BB-1:0] b_wr_data;
    logic [2*BB-1:0] b_rd_data;

    logic [IDW-1:0] run_id;
    logic [BB-1:0]  rem;
    logic [BB-1:0]  orig;
    logic [15:0]    q_eff;
    logic           done;
    logic [15:0]    slice;
    logic [32:0]    time_sum;
    logic [31:0]    time_sat;
    logic           add_ok;

    rrts_ram #(.WIDTH(IDW), .DEPTH(MAX_TASKS)) u_queue_ram (
        .aclk    (aclk),
        .wr_en   (q_wr_en),
        .wr_addr (tail_reg),
        .wr_data (q_wr_data),
        .rd_en   (cmd.q_rd),
        .rd_addr (head_reg),
        .rd_data (q_rd_data)
    );

    // Each entry holds the original burst above the remaining burst.
    rrts_ram #(.WIDTH(2 * BB), .DEPTH(MAX_TASKS)) u_burst_ram (
        .aclk    (aclk),
        .wr_en   (b_wr_en),
        .wr_addr (b_wr_addr),
        .wr_data (b_wr_data),
        .rd_en   (cmd.b_rd),
        .rd_addr (q_rd_data),
        .rd_data (b_rd_data)
    );

    function automatic logic [IDW-1:0] wrap_inc(input logic [IDW-1:0] p);
        logic [IDW-1:0] r;
        if (p == IDW'(MAX_TASKS - 1)) begin
            r = '0;
        end else begin
            r = p + IDW'(1);
        end
        return r;
    endfunction

    assign run_id = q_rd_data;
    assign rem    = b_rd_data[BB-1:0];
    assign orig   = b_rd_data[2*BB-1:BB];
    assign q_eff  = (quantum == 16'd0) ? 16'd1 : quantum;
    assign done   = !(CMPW'(rem) > CMPW'(q_eff));
    // A finishing slice is at most the quantum, so it fits in 16 bits.
    assign slice  = done ? 16'(rem) : q_eff;
    assign time_sum = {1'b0, time_reg} + {17'd0, slice};
    assign time_sat = time_sum[32] ? 32'hFFFF_FFFF : time_sum[31:0];
    assign add_ok = (count_reg != CW'(MAX_TASKS)) && (next_id_reg != CW'(MAX_TASKS));

    assign stat.q_empty  = (count_reg == '0);
    assign stat.out_free = !valid_reg || m_ready;

    always_comb begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        next_id_next    = next_id_reg;
        time_next       = time_reg;
        q_wr_en         = 1'b0;
        q_wr_data       = run_id;
        b_wr_en         = 1'b0;
        b_wr_addr       = run_id;
        b_wr_data       = {orig, rem - BB'(slice)};
        status_next     = rrts_pkg::ST_EMPTY;
        task_id_next    = '0;
        run_length_next = '0;
        finished_next   = 1'b0;
        wait_next       = '0;
        tat_next        = '0;

        if (mode_reg == rrts_pkg::MODE_ADD) begin
            if (add_ok) begin
                status_next  = rrts_pkg::ST_ADDED;
                task_id_next = 4'(next_id_reg[IDW-1:0]);
                q_wr_en      = cmd.commit;
                q_wr_data    = next_id_reg[IDW-1:0];
                b_wr_en      = cmd.commit;
                b_wr_addr    = next_id_reg[IDW-1:0];
                b_wr_data    = {burst_in_reg, burst_in_reg};
                tail_next    = wrap_inc(tail_reg);
                count_next   = count_reg + CW'(1);
                next_id_next = next_id_reg + CW'(1);
            end else begin
                status_next = rrts_pkg::ST_REJECTED;
            end
        end else if (count_reg != '0) begin
            status_next     = rrts_pkg::ST_RAN;
            task_id_next    = 4'(run_id);
            run_length_next = slice;
            time_next       = time_sat;
            head_next       = wrap_inc(head_reg);
            b_wr_en         = cmd.commit;
            if (done) begin
                b_wr_data     = {orig, {BB{1'b0}}};
                count_next    = count_reg - CW'(1);
                finished_next = 1'b1;
                tat_next      = time_sat;
                wait_next     = (time_sat >= 32'(orig)) ? time_sat - 32'(orig) : 32'd0;
            end else begin
                // Unfinished task goes back to the tail; the count is unchanged.
                q_wr_en   = cmd.commit;
                tail_next = wrap_inc(tail_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            next_id_reg <= '0;
            time_reg    <= '0;
            valid_reg   <= 1'b0;
        end else begin
            if (cmd.commit) begin
                head_reg    <= head_next;
                tail_reg    <= tail_next;
                count_reg   <= count_next;
                next_id_reg <= next_id_next;
                time_reg    <= time_next;
                valid_reg   <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            mode_reg     <= s_mode;
            burst_in_reg <= BB'(s_burst);
        end
        if (cmd.commit) begin
            status_reg     <= status_next;
            task_id_reg    <= task_id_next;
            run_length_reg <= run_length_next;
            finished_reg   <= finished_next;
            wait_reg       <= wait_next;
            tat_reg        <= tat_next;
        end
    end

    assign m_valid           = valid_reg;
    assign m_status          = status_reg;
    assign m_task_id         = task_id_reg;
    assign m_run_length      = run_length_reg;
    assign m_finished        = finished_reg;
    assign m_wait_time       = wait_reg;
    assign m_turnaround_time = tat_reg;
    assign m_elapsed_time    = time_reg;

endmodule
`default_nettype wire

// ===== design/round_robin_task_scheduler_top.sv =====
// Top level of the round-robin task scheduler: APB quantum register and the
// controller/datapath pair. Depends on rrts_pkg, rrts_ctrl and rrts_datapath.
//
//  Channel  Direction  Handshake        Payload
//  -------  ---------  ---------------  ------------------------------------------
//  cfg      in         APB psel/penable quantum at byte address 0
//  s_       in         s_valid/s_ready  mode, burst
//  m_       out        m_valid/m_ready  status, task_id, run_length, finished,
//                                       wait_time, turnaround_time, elapsed_time
//
// An add or an empty-queue run moves from acceptance to the commit state; a dispatching
// run passes a burst table read first (queue read, burst table read, commit through
// registered-read memories); the input is ready again the cycle after a commit.
// A transaction is accepted while the previous result waits in the output register;
// its commit stalls, holding the input off, until that result is taken.
// Reset is synchronous and needs no clearing pass; table contents start undefined.
`timescale 1ns / 1ps
`default_nettype none
module round_robin_task_scheduler_top #(
    parameter int MAX_TASKS  = rrts_pkg::DEF_MAX_TASKS,
    parameter int BURST_BITS = rrts_pkg::DEF_BURST_BITS
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [rrts_pkg::APB_ADDR_BITS-1:0] paddr,
    input  wire logic [rrts_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic      [rrts_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                    pready,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_mode,
    input  wire logic [15:0]                        s_burst,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [1:0]                              m_status,
    output logic [3:0]                              m_task_id,
    output logic [15:0]                             m_run_length,
    output logic                                    m_finished,
    output logic [31:0]                             m_wait_time,
    output logic [31:0]                             m_turnaround_time,
    output logic [31:0]                             m_elapsed_time
);

    logic [rrts_pkg::QUANTUM_BITS-1:0] quantum_reg;
    rrts_pkg::cmd_t                    cmd;
    rrts_pkg::stat_t                   stat;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quantum_reg <= rrts_pkg::QUANTUM_RESET;
        end else if (psel && penable && pwrite && paddr[2] == rrts_pkg::REG_QUANTUM) begin
            quantum_reg <= pwdata[rrts_pkg::QUANTUM_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == rrts_pkg::REG_QUANTUM) begin
            prdata = rrts_pkg::APB_DATA_BITS'(quantum_reg);
        end
    end

    rrts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_mode),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rrts_datapath #(
        .MAX_TASKS  (MAX_TASKS),
        .BURST_BITS (BURST_BITS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .quantum           (quantum_reg),
        .s_mode            (s_mode),
        .s_burst           (s_burst),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_task_id         (m_task_id),
        .m_run_length      (m_run_length),
        .m_finished        (m_finished),
        .m_wait_time       (m_wait_time),
        .m_turnaround_time (m_turnaround_time),
        .m_elapsed_time    (m_elapsed_time)
    );

endmodule
`default_nettype wire

// ===== dv/tb_round_robin_task_scheduler_top.sv =====
// Self-checking testbench for round_robin_task_scheduler_top: a directed table and random
// add/run traffic under several quantum settings, checked against a cycle-free scheduler model.
// Depends on rrts_pkg and the round_robin_task_scheduler_top RTL.
`timescale 1ns / 1ps
module tb_round_robin_task_scheduler_top;
    import rrts_pkg::*;

    localparam int NTASKS      = DEF_MAX_TASKS;
    localparam int PHASE_ITEMS = 122;
    localparam int DRAIN_WAIT  = 20;

    typedef struct packed {
        status_t     status;
        logic [3:0]  task_id;
        logic [15:0] run_length;
        logic        finished;
        logic [31:0] wait_time;
        logic [31:0] turnaround;
        logic [31:0] elapsed;
    } slot_result_t;

    typedef struct packed {
        logic         mode;
        logic [15:0]  burst;
        logic         typed;
        slot_result_t want;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic        s_mode;
    logic [15:0] s_burst;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [3:0]  m_task_id;
    logic [15:0] m_run_length;
    logic        m_finished;
    logic [31:0] m_wait_time;
    logic [31:0] m_turnaround_time;
    logic [31:0] m_elapsed_time;

    // Scheduler model state.
    logic [3:0]  queue_ids[NTASKS];
    logic [15:0] remaining_units[NTASKS];
    logic [15:0] original_units[NTASKS];
    int          head_idx;
    int          tail_idx;
    int          queued;
    int          next_id;
    logic [31:0] clock_units;
    logic [15:0] quantum_q;

    slot_result_t pending_results[$];
    stim_row_t    directed_rows[$];
    int           mismatch_count;

    round_robin_task_scheduler_top u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_burst           (s_burst),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_task_id         (m_task_id),
        .m_run_length      (m_run_length),
        .m_finished        (m_finished),
        .m_wait_time       (m_wait_time),
        .m_turnaround_time (m_turnaround_time),
        .m_elapsed_time    (m_elapsed_time)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("round_robin_task_scheduler_top test failed");
        $finish;
    end

    // Advances the scheduler model by one transaction and returns the result it produces.
    function automatic slot_result_t schedule_step(input logic mode, input logic [15:0] burst);
        slot_result_t r;
        logic [3:0]   id;
        logic [15:0]  q;
        logic [15:0]  slice;
        logic [32:0]  sum;
        logic         done;
        r = '0;
        if (mode == MODE_ADD) begin
            if (queued >= NTASKS || next_id >= NTASKS) begin
                r.status = ST_REJECTED;
            end else begin
                id = next_id[3:0];
                next_id++;
                remaining_units[id] = burst;
                original_units[id] = burst;
                queue_ids[tail_idx] = id;
                tail_idx = (tail_idx + 1) % NTASKS;
                queued++;
                r.status = ST_ADDED;
                r.task_id = id;
            end
        end else if (queued == 0) begin
            r.status = ST_EMPTY;
        end else begin
            id = queue_ids[head_idx];
            head_idx = (head_idx + 1) % NTASKS;
            queued--;
            // A zero quantum still grants one unit per turn.
            q = (quantum_q == 16'd0) ? 16'd1 : quantum_q;
            if (remaining_units[id] > q) begin
                slice = q;
                done = 1'b0;
            end else begin
                slice = remaining_units[id];
                done = 1'b1;
            end
            sum = {1'b0, clock_units} + {17'd0, slice};
            clock_units = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            r.status = ST_RAN;
            r.task_id = id;
            r.run_length = slice;
            if (!done) begin
                remaining_units[id] = remaining_units[id] - slice;
                queue_ids[tail_idx] = id;
                tail_idx = (tail_idx + 1) % NTASKS;
                queued++;
            end else begin
                remaining_units[id] = 16'd0;
                r.finished = 1'b1;
                r.wait_time = (clock_units >= {16'd0, original_units[id]}) ?
                              clock_units - {16'd0, original_units[id]} : 32'd0;
                r.turnaround = clock_units;
            end
        end
        r.elapsed = clock_units;
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic logic [15:0] pick_burst();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2, 3: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(1, 40));
        endcase
    endfunction

    task automatic add_row(input logic mode, input logic [15:0] burst, input logic typed,
                           input status_t st, input logic [3:0] id, input logic [15:0] len,
                           input logic fin, input logic [31:0] wt, input logic [31:0] tat,
                           input logic [31:0] el);
        stim_row_t row;
        row.mode = mode;
        row.burst = burst;
        row.typed = typed;
        row.want.status = st;
        row.want.task_id = id;
        row.want.run_length = len;
        row.want.finished = fin;
        row.want.wait_time = wt;
        row.want.turnaround = tat;
        row.want.elapsed = el;
        directed_rows.push_back(row);
    endtask

    // Presents one transaction, waits for its acceptance, records the expected result and
    // then, unless no_gap is set, may idle the input side for a random gap.
    task automatic send_item(input logic mode, input logic [15:0] burst, input logic typed,
                             input slot_result_t want, input bit no_gap);
        slot_result_t predicted;
        int           gap;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_mode <= mode;
        s_burst <= burst;
        do @(posedge aclk); while (!s_ready);
        predicted = schedule_step(mode, burst);
        pending_results.push_back(typed ? want : predicted);
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic apb_xfer(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {REG_QUANTUM, 2'b00};
        pwdata <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_quantum();
        logic [31:0] rd;
        apb_xfer(1'b0, 32'd0, rd);
        if (rd !== {16'd0, quantum_q}) begin
            if (mismatch_count < 10)
                $display("quantum readback: expected %0d, got %0d", quantum_q, rd);
            mismatch_count++;
        end
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (8) @(posedge aclk);
    endtask

    // Results are checked in order against the oldest outstanding expectation.
    always @(posedge aclk) begin
        slot_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected result: status %0d task %0d", m_status, m_task_id);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status || m_task_id !== want.task_id ||
                    m_run_length !== want.run_length || m_finished !== want.finished ||
                    m_wait_time !== want.wait_time || m_turnaround_time !== want.turnaround ||
                    m_elapsed_time !== want.elapsed) begin
                    if (mismatch_count < 10) begin
                        $display("result mismatch at %0t ns", $realtime);
                        $display("  expected st %0d id %0d len %0d fin %0d wait %0d tat %0d el %0d",
                                 want.status, want.task_id, want.run_length, want.finished,
                                 want.wait_time, want.turnaround, want.elapsed);
                        $display("  actual   st %0d id %0d len %0d fin %0d wait %0d tat %0d el %0d",
                                 m_status, m_task_id, m_run_length, m_finished,
                                 m_wait_time, m_turnaround_time, m_elapsed_time);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // Output back-pressure: stretches of readiness broken by short and occasional long stalls.
    initial begin
        int n_on;
        int n_off;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            n_on = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
            n_off = pick_gap();
            m_ready <= 1'b1;
            repeat (n_on) @(negedge aclk);
            if (n_off > 0) begin
                m_ready <= 1'b0;
                repeat (n_off) @(negedge aclk);
            end
        end
    end

    initial begin
        logic [31:0] quanta[6];
        logic [31:0] rd;
        logic        mode;
        logic [15:0] burst;
        stim_row_t   row;

        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_valid = 1'b0;
        s_mode = 1'b0;
        s_burst = '0;
        mismatch_count = 0;
        head_idx = 0;
        tail_idx = 0;
        queued = 0;
        next_id = 0;
        clock_units = '0;
        quantum_q = QUANTUM_RESET;
        for (int i = 0; i < NTASKS; i++) begin
            queue_ids[i] = '0;
            remaining_units[i] = '0;
            original_units[i] = '0;
        end
        quanta[0] = 32'd1;
        quanta[1] = 32'd3;
        quanta[2] = 32'd65535;
        quanta[3] = 32'd0;
        quanta[4] = 32'hABCD_0007;
        quanta[5] = 32'd25;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        check_quantum();

        // Run on an empty queue, extreme bursts, a zero-burst task, a burst equal to the
        // quantum, and tasks that need several turns.
        add_row(MODE_RUN, 16'hFFFF, 1'b1, ST_EMPTY, 4'd0, 16'd0, 1'b0, 32'd0, 32'd0, 32'd0);
        add_row(MODE_ADD, 16'h0000, 1'b1, ST_ADDED, 4'd0, 16'd0, 1'b0, 32'd0, 32'd0, 32'd0);
        add_row(MODE_ADD, 16'hFFFF, 1'b1, ST_ADDED, 4'd1, 16'd0, 1'b0, 32'd0, 32'd0, 32'd0);
        add_row(MODE_ADD, 16'd1, 1'b1, ST_ADDED, 4'd2, 16'd0, 1'b0, 32'd0, 32'd0, 32'd0);
        add_row(MODE_ADD, 16'd10, 1'b0, ST_ADDED, 4'd0, 16'd0, 1'b0, 32'd0, 32'd0, 32'd0);
        add_row(MODE_ADD, 16'd11, 1'b0, ST_ADDED, 4'd0, 16'd0, 1'b0, 32'd0, 32'd0, 32'd0);
        add_row(MODE_RUN, 16'd0, 1'b1, ST_RAN, 4'd0, 16'd0, 1'b1, 32'd0, 32'd0, 32'd0);
        for (int i = 0; i < 6; i++)
            add_row(MODE_RUN, 16'h5555, 1'b0, ST_RAN, 4'd0, 16'd0, 1'b0, 32'd0, 32'd0, 32'd0);
        add_row(MODE_ADD, 16'hA5A5, 1'b0, ST_ADDED, 4'd0, 16'd0, 1'b0, 32'd0, 32'd0, 32'd0);
        add_row(MODE_ADD, 16'h5A5A, 1'b0, ST_ADDED, 4'd0, 16'd0, 1'b0, 32'd0, 32'd0, 32'd0);
        for (int i = 0; i < 7; i++)
            add_row(MODE_RUN, 16'hAAAA, 1'b0, ST_RAN, 4'd0, 16'd0, 1'b0, 32'd0, 32'd0, 32'd0);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_item(row.mode, row.burst, row.typed, row.want, 1'b0);
        end

        for (int p = 0; p < 6; p++) begin
            wait_idle();
            apb_xfer(1'b1, quanta[p], rd);
            quantum_q = quanta[p][15:0];
            check_quantum();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Task numbers are never reused, so adds are kept rare to spread the
                // sixteen tasks over several quantum settings; later adds are rejected.
                if ($urandom_range(0, 99) < ((next_id < NTASKS) ? 10 : 6))
                    mode = MODE_ADD;
                else
                    mode = MODE_RUN;
                burst = (mode == MODE_ADD) ? pick_burst() : 16'($urandom_range(0, 65535));
                send_item(mode, burst, 1'b0, '0, (n % 60) < 12);
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("round_robin_task_scheduler_top test passed");
        end else begin
            $display("round_robin_task_scheduler_top test failed");
        end
        $finish;
    end

endmodule
